FILE: design/rsa_letter_modexp_cipher_unit_defines.svh
// Assertion macros shared by the cipher unit.
`ifndef RSA_LETTER_MODEXP_CIPHER_UNIT_DEFINES_SVH
`define RSA_LETTER_MODEXP_CIPHER_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define RLMC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every clock edge outside reset.
`define RLMC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/rlmc_pkg.sv
package rlmc_pkg;

    localparam int DATA_W = 31;
    localparam int CFG_IDX_W = 2;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_PUBLIC_EXP  = 2'd0;
    localparam t_cfg_idx CFG_PRIVATE_EXP = 2'd1;
    localparam t_cfg_idx CFG_MODULUS     = 2'd2;

    localparam logic [DATA_W-1:0] LETTER_FIRST = 31'd65;
    localparam logic [DATA_W-1:0] LETTER_LAST  = 31'd90;
    localparam logic [DATA_W-1:0] LETTER_COUNT = 31'd26;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_STEP,
        ST_DONE
    } t_state;

endpackage

FILE: design/rsa_letter_modexp_cipher_unit.sv
// Channel   | Direction | Handshake                     | Payload
// ----------+-----------+-------------------------------+------------------------------
// input     | in        | i_in_valid / o_in_stall       | i_action, i_data_value
// output    | out       | o_out_valid / i_out_stall     | o_result_value
// config    | in        | i_cfg_valid / o_cfg_ready     | i_cfg_index, i_cfg_data
//
// Sequence: an item runs a reduction pass over its input value, then one exponent step per
//   exponent bit up to the highest set bit; an exponent of zero skips the reduction and
//   the steps alike. Each pass runs on the bit-serial modular multiplier, which takes one
//   multiplier bit per cycle.
// Reset: synchronous, active low; clears the sequencer, the output valid and sets all
//   three configuration registers to 1.
// Stalls: a finished result sits in the output register while the next item is accepted;
//   the sequencer waits in its final state only if that register is still occupied.
`include "rsa_letter_modexp_cipher_unit_defines.svh"

module rsa_letter_modexp_cipher_unit
    import rlmc_pkg::*;
#(
    parameter int MOD_BITS = 31
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Input item channel.
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_action,
    input  logic [DATA_W-1:0] i_data_value,
    // Result channel.
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [DATA_W-1:0] o_result_value,
    // Configuration write channel.
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  t_cfg_idx          i_cfg_index,
    input  logic [DATA_W-1:0] i_cfg_data
);

    // The multiplier bit scan must cover both the raw input value (for the initial
    // reduction) and any residue below the modulus.
    localparam int SCAN_W = (MOD_BITS > DATA_W) ? MOD_BITS : DATA_W;
    localparam int CNT_W  = $clog2(SCAN_W);

    // One step of the bit-serial modular multiplier: r <- (2r + bit*a) mod m.
    // With r, a < m the sum stays below 3m, so at most two subtractions of m are
    // needed and both are decided in parallel.
    function automatic logic [MOD_BITS-1:0] mod_step(
        input logic [MOD_BITS-1:0] r,
        input logic                b,
        input logic [MOD_BITS-1:0] a,
        input logic [MOD_BITS-1:0] m
    );
        logic [MOD_BITS+1:0] sum;
        logic [MOD_BITS+1:0] m1;
        logic [MOD_BITS+1:0] m2;
        logic [MOD_BITS+1:0] res;
        sum = {1'b0, r, 1'b0} + (b ? {2'b00, a} : '0);
        m1  = {2'b00, m};
        m2  = {1'b0, m, 1'b0};
        if (sum >= m2) begin
            res = sum - m2;
        end else if (sum >= m1) begin
            res = sum - m1;
        end else begin
            res = sum;
        end
        return res[MOD_BITS-1:0];
    endfunction

    // Configuration registers.
    logic [DATA_W-1:0]   r_pub_exp;
    logic [DATA_W-1:0]   r_priv_exp;
    logic [MOD_BITS-1:0] r_mod;

    // Sequencer and datapath registers.
    t_state              r_state, n_state;
    logic                r_action, n_action;
    logic [DATA_W-1:0]   r_expo, n_expo;
    logic [MOD_BITS-1:0] r_base, n_base;
    logic [MOD_BITS-1:0] r_acc, n_acc;
    logic [MOD_BITS-1:0] r_p, n_p;
    logic [MOD_BITS-1:0] r_q, n_q;
    logic [SCAN_W-1:0]   r_bsh, n_bsh;
    logic [CNT_W-1:0]    r_cnt, n_cnt;

    // Output register.
    logic                r_out_valid;
    logic [DATA_W-1:0]   r_result;

    logic                in_fire;
    logic                cfg_fire;
    logic                out_free;
    logic                out_load;
    logic                is_letter;
    logic [DATA_W-1:0]   sel_expo;
    logic [MOD_BITS-1:0] m_eff;
    logic [MOD_BITS-1:0] one_m;
    logic                cnt_last;
    logic                scan_bit;
    logic [MOD_BITS-1:0] step_p;
    logic [MOD_BITS-1:0] step_q;
    logic [DATA_W-1:0]   expo_shr;
    logic [SCAN_W-1:0]   acc_ext;
    logic                dec_ok;
    logic [DATA_W-1:0]   result_value;

    assign in_fire   = i_in_valid && !o_in_stall;
    assign cfg_fire  = i_cfg_valid && o_cfg_ready;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign is_letter = i_data_value inside {[LETTER_FIRST:LETTER_LAST]};
    assign sel_expo  = i_action ? r_priv_exp : r_pub_exp;

    // A modulus of zero behaves as a modulus of one; one_m is 1 mod m.
    assign m_eff = (r_mod == '0) ? MOD_BITS'(1) : r_mod;
    assign one_m = (m_eff == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);

    assign cnt_last = (r_cnt == '0);
    assign scan_bit = r_bsh[SCAN_W-1];
    assign expo_shr = r_expo >> 1;

    // In the reduction pass lane p multiplies 1 by the input value (for encrypt the letter
    // index 1..26); in exponent steps p forms acc * base, q forms base * base, from the same bits.
    assign step_p = mod_step(r_p, scan_bit, (r_state == ST_REDUCE) ? one_m : r_acc, m_eff);
    assign step_q = mod_step(r_q, scan_bit, r_base, m_eff);

    // Final formatting of the power: the residue for encrypt, a capital letter for a
    // decrypt outcome in 1..26.
    assign acc_ext      = SCAN_W'(r_acc);
    assign dec_ok       = (acc_ext[DATA_W-1:0] >= DATA_W'(1))
                          && (acc_ext[DATA_W-1:0] <= LETTER_COUNT)
                          && (acc_ext == SCAN_W'(acc_ext[DATA_W-1:0]));
    assign result_value = r_action ? (acc_ext[DATA_W-1:0] + LETTER_FIRST - DATA_W'(1))
                                   : acc_ext[DATA_W-1:0];

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    if (!i_action && !is_letter) begin
                        n_state = ST_IDLE;
                    end else if (sel_expo == '0) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE: begin
                if (cnt_last) begin
                    n_state = ST_STEP;
                end
            end
            ST_STEP: begin
                if (cnt_last && (expo_shr == '0)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if ((r_action && !dec_ok) || out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output logic of the sequencer.
    always_comb begin
        o_in_stall = 1'b1;
        out_load   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
            end
            ST_DONE: begin
                out_load = out_free && (!r_action || dec_ok);
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    // Datapath next values.
    always_comb begin
        n_action = r_action;
        n_expo   = r_expo;
        n_base   = r_base;
        n_acc    = r_acc;
        n_p      = r_p;
        n_q      = r_q;
        n_bsh    = r_bsh;
        n_cnt    = r_cnt;
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_action = i_action;
                    n_expo   = sel_expo;
                    n_acc    = MOD_BITS'(1);
                    n_p      = '0;
                    n_q      = '0;
                    n_cnt    = CNT_W'(SCAN_W - 1);
                    if (i_action) begin
                        n_bsh = SCAN_W'(i_data_value);
                    end else begin
                        n_bsh = SCAN_W'(i_data_value - LETTER_FIRST + DATA_W'(1));
                    end
                end
            end
            ST_REDUCE: begin
                n_p   = step_p;
                n_bsh = r_bsh << 1;
                n_cnt = r_cnt - CNT_W'(1);
                if (cnt_last) begin
                    n_base = step_p;
                    n_acc  = one_m;
                    n_bsh  = SCAN_W'(step_p);
                    n_p    = '0;
                    n_q    = '0;
                    n_cnt  = CNT_W'(SCAN_W - 1);
                end
            end
            ST_STEP: begin
                n_p   = step_p;
                n_q   = step_q;
                n_bsh = r_bsh << 1;
                n_cnt = r_cnt - CNT_W'(1);
                if (cnt_last) begin
                    if (r_expo[0]) begin
                        n_acc = step_p;
                    end
                    n_base = step_q;
                    n_expo = expo_shr;
                    n_bsh  = SCAN_W'(step_q);
                    n_p    = '0;
                    n_q    = '0;
                    n_cnt  = CNT_W'(SCAN_W - 1);
                end
            end
            default: begin
                n_cnt = r_cnt;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_pub_exp   <= DATA_W'(1);
            r_priv_exp  <= DATA_W'(1);
            r_mod       <= MOD_BITS'(1);
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_fire) begin
                case (i_cfg_index)
                    CFG_PUBLIC_EXP:  r_pub_exp  <= i_cfg_data;
                    CFG_PRIVATE_EXP: r_priv_exp <= i_cfg_data;
                    CFG_MODULUS:     r_mod      <= MOD_BITS'(i_cfg_data);
                    default: begin
                        r_mod <= r_mod;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_action <= n_action;
        r_expo   <= n_expo;
        r_base   <= n_base;
        r_acc    <= n_acc;
        r_p      <= n_p;
        r_q      <= n_q;
        r_bsh    <= n_bsh;
        r_cnt    <= n_cnt;
        if (out_load) begin
            r_result <= result_value;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_result;
    assign o_cfg_ready    = 1'b1;

    // The partial products of both lanes always stay below the modulus.
    `RLMC_ASSERT_NOW(a_lanes_reduced, (r_state == ST_REDUCE) || (r_state == ST_STEP), (r_p < m_eff) && (r_q < m_eff), "multiplier lane left the residue range")
    // Accumulator and base are residues while the exponent is being walked.
    `RLMC_ASSERT_NOW(a_operands_reduced, r_state == ST_STEP, (r_acc < m_eff) && (r_base < m_eff), "operand not reduced modulo n")
    // The exponent walk ends as soon as no set bit remains.
    `RLMC_ASSERT_NOW(a_expo_live, r_state == ST_STEP, r_expo != '0, "exponent step with zero exponent")
    // A decrypt result is always a capital letter code.
    `RLMC_ASSERT_NEXT(a_dec_letter, out_load && r_action, (o_result_value >= LETTER_FIRST) && (o_result_value <= LETTER_LAST), "decrypt result outside A..Z")

endmodule
